// ===== rtl/ntclf_pkg.sv =====
// ----------------------------------------------------------------------------
// ntclf_pkg
// Shared constants, register indexes and the log2 table builder for the NTC
// thermistor linearizer.
// ----------------------------------------------------------------------------
package ntclf_pkg;

   localparam int DEF_CHANNELS       = 3;
   localparam int DEF_MIN_VALID_MV   = 100;
   localparam int DEF_MAX_VALID_MV   = 3200;
   localparam int DEF_LOG_TABLE_BITS = 8;

   localparam int ZERO_C_CENTIKELVIN = 27315;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_REFERENCE_MV  = 3'd0;
   localparam csr_index_type REG_FIXED_RES     = 3'd1;
   localparam csr_index_type REG_NOMINAL_RES   = 3'd2;
   localparam csr_index_type REG_NOMINAL_TEMP  = 3'd3;
   localparam csr_index_type REG_BETA          = 3'd4;
   localparam csr_index_type REG_FILTER_WEIGHT = 3'd5;
   localparam csr_index_type REG_TEMP_LOW      = 3'd6;
   localparam csr_index_type REG_TEMP_HIGH     = 3'd7;

   // log2(1 + i/2^bits) in Q16, built by repeated truncating squaring in Q1.30.
   function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned bits);
      logic [63:0] y;
      logic [16:0] r;
      r = '0;
      if (i >= (32'd1 << bits)) begin
         r = 17'd65536;
      end else begin
         y = (64'd1 << 30) + (64'(i) << (30 - bits));
         for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               r[15-k] = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/ntc_thermistor_linearizer_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ntc_thermistor_linearizer_filter_unit
// Converts a divider voltage to a filtered temperature in 0.01 degC.
// ----------------------------------------------------------------------------
// An input beat passes through the bit-serial normalizer, the log2 steps, the
// 2-bit digit serial ln multiply and the restoring divider, in that order; the
// divider is skipped when the temperature is clipped hot ahead of the divide.
// The next input is taken once the previous result is in the output register,
// so only one beat is in flight. Reset clears every channel's average and flag.
module ntc_thermistor_linearizer_filter_unit #(
   parameter int CHANNELS       = ntclf_pkg::DEF_CHANNELS,
   parameter int MIN_VALID_MV   = ntclf_pkg::DEF_MIN_VALID_MV,
   parameter int MAX_VALID_MV   = ntclf_pkg::DEF_MAX_VALID_MV,
   parameter int LOG_TABLE_BITS = ntclf_pkg::DEF_LOG_TABLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_channel,
   input  logic [11:0]                       req_sample_mv,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_channel_out,
   output logic [11:0]                       rsp_raw_mv,
   output logic signed [15:0]                rsp_filtered_temp,
   output logic                              rsp_reading_ok,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ntclf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ntclf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ntclf_pkg::*;

   localparam int L    = LOG_TABLE_BITS;
   localparam int TABN = 1 << L;
   localparam int REMW = 19 - L;
   localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_NORM = 4'd1;
   localparam logic [3:0] ST_LOG  = 4'd2;
   localparam logic [3:0] ST_LN   = 4'd3;
   localparam logic [3:0] ST_MUL1 = 4'd4;
   localparam logic [3:0] ST_MUL2 = 4'd5;
   localparam logic [3:0] ST_DEN  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_TEMP = 4'd8;
   localparam logic [3:0] ST_FILT = 4'd9;
   localparam logic [3:0] ST_UPD  = 4'd10;

   // Constant log2 table, one entry per fraction step plus the end point.
   logic [16:0] tab [0:TABN];
   for (genvar gi = 0; gi <= TABN; gi++) begin : g_tab
      localparam logic [16:0] ENTRY = log_entry(gi, L);
      assign tab[gi] = ENTRY;
   end

   // Configuration registers.
   logic [11:0]        vref_ff, vref_in;
   logic [19:0]        rf_ff, rf_in, r0_ff, r0_in;
   logic [15:0]        t0_ff, t0_in, beta_ff, beta_in, w_ff, w_in;
   logic signed [15:0] lo_ff, lo_in, hi_ff, hi_in;

   // Sequencer and datapath registers.
   logic [3:0]         state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [1:0]         ch_ff, ch_in;
   logic [11:0]        mv_ff, mv_in;
   logic [19:0]        n_ff [4];
   logic [19:0]        n_in [4];
   logic [4:0]         s_ff [4];
   logic [4:0]         s_in [4];
   logic signed [22:0] l2_ff, l2_in;
   logic [21:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [51:0]        acc_ff, acc_in;
   logic signed [22:0] ln_ff, ln_in;
   logic [31:0]        bt_ff, bt_in;
   logic [22:0]        b100_ff, b100_in;
   logic signed [39:0] tl_ff, tl_in;
   logic [54:0]        num_ff, num_in;
   logic [55:0]        rem_ff, rem_in, dv_ff, dv_in;
   logic [16:0]        q_ff, q_in;
   logic signed [15:0] tsat_ff, tsat_in;
   logic               tok_ff, tok_in;
   logic signed [41:0] p_ff, p_in;

   // Per-channel filter state.
   logic signed [23:0] avg_ff [CHANNELS];
   logic signed [23:0] avg_in [CHANNELS];
   logic [CHANNELS-1:0] seeded_ff, seeded_in;

   // Result register.
   logic               ov_ff, ov_in;
   logic [1:0]         och_ff, och_in;
   logic [11:0]        omv_ff, omv_in;
   logic signed [15:0] otemp_ff, otemp_in;
   logic               ook_ff, ook_in;

   // Combinational helpers.
   logic [15:0]        beta1, t01;
   logic [19:0]        rf1, r01;
   logic [11:0]        vcl, dcl;
   logic [1:0]         k;
   logic [19:0]        nk;
   logic [L-1:0]       tidx;
   logic [L:0]         tlo_i, thi_i;
   logic [16:0]        tlo, thi, tdiff;
   logic [REMW-1:0]    trem;
   logic [REMW+16:0]   tprod;
   logic [4:0]         ex;
   logic [20:0]        logv;
   logic signed [22:0] l2_next;
   logic [31:0]        dmul;
   logic [21:0]        lnm;
   logic signed [40:0] den;
   logic [55:0]        numr;
   logic               ovf;
   logic signed [17:0] temp;
   logic               ch_ok, mv_ok;
   logic [CW-1:0]      cidx;
   logic signed [23:0] oldv, xv, avg_new;
   logic signed [24:0] diff, rnd;
   logic signed [25:0] upd;
   logic               all_norm;

   assign beta1 = (beta_ff == '0) ? 16'd1 : beta_ff;
   assign t01   = (t0_ff == '0) ? 16'd1 : t0_ff;
   assign rf1   = (rf_ff == '0) ? 20'd1 : rf_ff;
   assign r01   = (r0_ff == '0) ? 20'd1 : r0_ff;

   // Clamp of the sample into 1..vref-1 and the divider difference.
   always_comb begin
      if (vref_ff < 12'd2) begin
         vcl = 12'd1;
         dcl = 12'd1;
      end else begin
         vcl = (req_sample_mv == '0) ? 12'd1 : req_sample_mv;
         if (vcl > vref_ff - 12'd1) begin
            vcl = vref_ff - 12'd1;
         end
         dcl = vref_ff - vcl;
      end
   end

   // Shared log2 unit: operand picked by the step counter, normalized to bit 19.
   assign k     = cnt_ff[1:0];
   assign nk    = n_ff[k];
   assign tidx  = nk[18 -: L];
   assign trem  = nk[REMW-1:0];
   assign tlo_i = {1'b0, tidx};
   assign thi_i = tlo_i + 1'b1;
   assign tlo   = tab[tlo_i];
   assign thi   = tab[thi_i];
   assign tdiff = thi - tlo;
   assign tprod = tdiff * trem;
   assign ex    = 5'd19 - s_ff[k];
   assign logv  = {ex, 16'b0} + 21'(tlo) + 21'(tprod >> REMW);
   assign l2_next = (k < 2'd2) ? l2_ff + 23'(logv) : l2_ff - 23'(logv);

   always_comb begin
      case (mag_ff[21:20])
         2'd0:    dmul = '0;
         2'd1:    dmul = 32'(LN2_Q30);
         2'd2:    dmul = {1'b0, LN2_Q30, 1'b0};
         default: dmul = 32'(LN2_Q30) + {1'b0, LN2_Q30, 1'b0};
      endcase
   end

   assign lnm  = 22'((acc_ff + 52'd536870912) >> 30);
   assign den  = $signed({2'b0, b100_ff, 16'b0}) + 41'(tl_ff);
   assign numr = {1'b0, num_ff} + 56'(den[39:1]);
   assign ovf  = {1'b0, numr} >= {den[39:0], 17'b0};
   assign temp = $signed({1'b0, q_ff}) - 18'sd27315;

   assign ch_ok = {30'b0, ch_ff} < CHANNELS;
   assign mv_ok = (mv_ff >= 12'(MIN_VALID_MV)) && (mv_ff <= 12'(MAX_VALID_MV));
   assign cidx  = CW'(ch_ff);
   assign oldv  = avg_ff[cidx];
   assign xv    = {tsat_ff, 8'b0};
   assign diff  = 25'(xv) - 25'(oldv);
   assign rnd   = 25'((p_ff + 42'sd32768) >>> 16);
   assign upd   = 26'(oldv) + 26'(rnd);
   assign avg_new = seeded_ff[cidx] ? upd[23:0] : xv;

   always_comb begin
      all_norm = 1'b1;
      for (int i = 0; i < 4; i++) begin
         all_norm = all_norm & n_ff[i][19];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      vref_in = vref_ff;
      rf_in   = rf_ff;
      r0_in   = r0_ff;
      t0_in   = t0_ff;
      beta_in = beta_ff;
      w_in    = w_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_REFERENCE_MV:  vref_in = csr_wdata[11:0];
            REG_FIXED_RES:     rf_in   = csr_wdata;
            REG_NOMINAL_RES:   r0_in   = csr_wdata;
            REG_NOMINAL_TEMP:  t0_in   = csr_wdata[15:0];
            REG_BETA:          beta_in = csr_wdata[15:0];
            REG_FILTER_WEIGHT: w_in    = csr_wdata[15:0];
            REG_TEMP_LOW:      lo_in   = csr_wdata[15:0];
            REG_TEMP_HIGH:     hi_in   = csr_wdata[15:0];
            default:           vref_in = vref_ff;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ch_in     = ch_ff;
      mv_in     = mv_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      l2_in     = l2_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      ln_in     = ln_ff;
      bt_in     = bt_ff;
      b100_in   = b100_ff;
      tl_in     = tl_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      dv_in     = dv_ff;
      q_in      = q_ff;
      tsat_in   = tsat_ff;
      tok_in    = tok_ff;
      p_in      = p_ff;
      avg_in    = avg_ff;
      seeded_in = seeded_ff;
      ov_in     = ov_ff & ~rsp_ready;
      och_in    = och_ff;
      omv_in    = omv_ff;
      otemp_in  = otemp_ff;
      ook_in    = ook_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in    = req_channel;
               mv_in    = req_sample_mv;
               n_in[0]  = rf1;
               n_in[1]  = {8'b0, vcl};
               n_in[2]  = {8'b0, dcl};
               n_in[3]  = r01;
               for (int i = 0; i < 4; i++) begin
                  s_in[i] = '0;
               end
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // One bit position per cycle until every operand has its leading one at the top.
            for (int i = 0; i < 4; i++) begin
               if (!n_ff[i][19]) begin
                  n_in[i] = {n_ff[i][18:0], 1'b0};
                  s_in[i] = s_ff[i] + 5'd1;
               end
            end
            if (all_norm) begin
               cnt_in   = '0;
               l2_in    = '0;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            l2_in  = l2_next;
            cnt_in = cnt_ff + 5'd1;
            if (k == 2'd3) begin
               neg_in   = l2_next[22];
               mag_in   = l2_next[22] ? 22'(-l2_next) : l2_next[21:0];
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            acc_in = {acc_ff[49:0], 2'b0} + 52'(dmul);
            mag_in = {mag_ff[19:0], 2'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd10) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ln_in    = neg_ff ? -$signed({1'b0, lnm}) : $signed({1'b0, lnm});
            bt_in    = beta1 * t01;
            b100_in  = beta1 * 7'd100;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            tl_in    = $signed({1'b0, t01}) * ln_ff;
            num_in   = {39'(bt_ff * 7'd100), 16'b0};
            state_in = ST_DEN;
         end
         ST_DEN: begin
            if (den <= 0 || ovf) begin
               // Unboundedly hot, or far above the 16-bit range: clip and flag.
               tsat_in  = 16'sd32767;
               tok_in   = 1'b0;
               state_in = ST_FILT;
            end else begin
               rem_in   = numr;
               dv_in    = {den[39:0], 16'b0};
               q_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= dv_ff) begin
               rem_in = rem_ff - dv_ff;
               q_in   = {q_ff[15:0], 1'b1};
            end else begin
               q_in   = {q_ff[15:0], 1'b0};
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = ST_TEMP;
            end
         end
         ST_TEMP: begin
            tsat_in  = (temp > 18'sd32767) ? 16'sd32767 : temp[15:0];
            tok_in   = (temp >= 18'(lo_ff)) && (temp <= 18'(hi_ff));
            state_in = ST_FILT;
         end
         ST_FILT: begin
            p_in     = diff * $signed({1'b0, w_ff});
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!ov_ff || rsp_ready) begin
               ov_in  = 1'b1;
               och_in = ch_ff;
               omv_in = mv_ff;
               if (ch_ok) begin
                  avg_in[cidx]    = avg_new;
                  seeded_in[cidx] = 1'b1;
                  otemp_in = 16'(25'(25'(avg_new) + 25'sd128) >>> 8);
                  ook_in   = tok_ff & mv_ok;
               end else begin
                  otemp_in = tsat_ff;
                  ook_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff   <= 12'd3300;
         rf_ff     <= 20'd10000;
         r0_ff     <= 20'd10000;
         t0_ff     <= 16'd29815;
         beta_ff   <= 16'd3950;
         w_ff      <= 16'd6554;
         lo_ff     <= -16'sd4000;
         hi_ff     <= 16'sd12500;
         state_ff  <= ST_IDLE;
         ov_ff     <= 1'b0;
         seeded_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         vref_ff   <= vref_in;
         rf_ff     <= rf_in;
         r0_ff     <= r0_in;
         t0_ff     <= t0_in;
         beta_ff   <= beta_in;
         w_ff      <= w_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         state_ff  <= state_in;
         ov_ff     <= ov_in;
         seeded_ff <= seeded_in;
         avg_ff    <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      ch_ff    <= ch_in;
      mv_ff    <= mv_in;
      n_ff     <= n_in;
      s_ff     <= s_in;
      l2_ff    <= l2_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      ln_ff    <= ln_in;
      bt_ff    <= bt_in;
      b100_ff  <= b100_in;
      tl_ff    <= tl_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      dv_ff    <= dv_in;
      q_ff     <= q_in;
      tsat_ff  <= tsat_in;
      tok_ff   <= tok_in;
      p_ff     <= p_in;
      och_ff   <= och_in;
      omv_ff   <= omv_in;
      otemp_ff <= otemp_in;
      ook_ff   <= ook_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_channel_out   = och_ff;
   assign rsp_raw_mv        = omv_ff;
   assign rsp_filtered_temp = otemp_ff;
   assign rsp_reading_ok    = ook_ff;

endmodule
